>>> hdl/clcd_pkg.sv
// Shared types, command codes and controller byte constants for the character LCD sequencer.
`default_nettype none

package clcd_pkg;

  // Port and field widths.
  localparam int CMD_W     = 4;
  localparam int SDATA_W   = 32;
  localparam int MDATA_W   = 8;
  localparam int COLS_W    = 6;
  localparam int ROWS_W    = 3;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int NIB_IDX_W = 4;

  // Job queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register reset values and the row count limit.
  localparam logic [COLS_W-1:0] COLS_RESET    = 6'd20;
  localparam logic [ROWS_W-1:0] ROWS_RESET    = 3'd4;
  localparam logic [ROWS_W-1:0] ROW_LIMIT_MAX = 3'd4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } cfg_idx_t;

  // Command codes of an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT       = 4'd0,
    CMD_PUT_CHAR   = 4'd1,
    CMD_SET_CURSOR = 4'd2,
    CMD_PUT_CUSTOM = 4'd3,
    CMD_CLEAR      = 4'd4,
    CMD_FLAG       = 4'd5,
    CMD_SCROLL     = 4'd6,
    CMD_CGRAM_SEL  = 4'd7,
    CMD_RAW_DATA   = 4'd8
  } cmd_t;

  // Targets of the flag command.
  typedef enum logic [1:0] {
    FLAG_DISPLAY = 2'd0,
    FLAG_CURSOR  = 2'd1,
    FLAG_BLINK   = 2'd2
  } flag_sel_t;

  // Controller instruction bytes.
  localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
  localparam logic [7:0] LCD_SET_CGRAM   = 8'h40;
  localparam logic [7:0] LCD_CLEAR       = 8'h01;
  localparam logic [7:0] LCD_DISP_CTRL   = 8'h08;
  localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] LCD_FUNC_2LINE  = 8'h28;
  localparam logic [7:0] LCD_FUNC_1LINE  = 8'h20;
  localparam logic [7:0] LCD_SHIFT_LEFT  = 8'h18;
  localparam logic [7:0] LCD_SHIFT_RIGHT = 8'h1C;

  // Power-up nibbles that put the controller into 4-bit mode.
  localparam logic [3:0] WAKE_NIB  = 4'h3;
  localparam logic [3:0] MODE4_NIB = 4'h2;

  // Flags after init: display on, cursor and blink off.
  localparam logic [2:0] FLAGS_INIT = 3'b100;
  localparam logic [7:0] INIT_DISP  = LCD_DISP_CTRL | {5'b0, FLAGS_INIT};

  // Number of nibbles in the init run.
  localparam logic [NIB_IDX_W-1:0] INIT_NIBBLES = 4'd12;

  // Character codes with cursor meaning.
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // One unit of work for the back end: an init run or one or two bytes.
  typedef struct packed {
    logic       init;
    logic       two;
    logic       rs0;
    logic [7:0] b0;
    logic       rs1;
    logic [7:0] b1;
  } job_t;

  // Display address of the first column of each row.
  function automatic logic [6:0] row_base(input logic [1:0] r);
    logic [6:0] base;
    unique case (r)
      2'd0: base = 7'h00;
      2'd1: base = 7'h40;
      2'd2: base = 7'h14;
      2'd3: base = 7'h54;
      default: base = 7'h00;
    endcase
    return base;
  endfunction

  // Nibble at a given position of the init run; fset is the function-set byte.
  function automatic logic [3:0] init_nibble(input logic [NIB_IDX_W-1:0] idx,
                                             input logic [7:0] fset);
    logic [3:0] nib;
    unique case (idx)
      4'd0, 4'd1, 4'd2: nib = WAKE_NIB;
      4'd3:  nib = MODE4_NIB;
      4'd4:  nib = fset[7:4];
      4'd5:  nib = fset[3:0];
      4'd6:  nib = INIT_DISP[7:4];
      4'd7:  nib = INIT_DISP[3:0];
      4'd8:  nib = LCD_CLEAR[7:4];
      4'd9:  nib = LCD_CLEAR[3:0];
      4'd10: nib = LCD_ENTRY_MODE[7:4];
      4'd11: nib = LCD_ENTRY_MODE[3:0];
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

`default_nettype wire

>>> hdl/character_lcd_4bit_command_sequencer_top.sv
// Top level of the character LCD command sequencer for a 4-bit controller interface.
//
// Commands enter on the s_ channel, one command per transfer; the command code rides in
// s_tuser and its operands in s_tdata. Each command leaves as a run of 4-bit transfers on
// the m_ channel: m_tdata carries the nibble, high nibble of a byte first, m_tuser is the
// register-select bit (1 for character data) and m_tlast marks the final nibble of a run.
// Runs are 2 nibbles for single-byte commands, 4 for a character that wraps or a custom
// glyph, 12 for init; flag commands with the spare selector and unknown codes send nothing.
// The front end takes a command every cycle while its four-job queue has room, and the
// first nibble passes through the queue and the job register to the output register. The
// output moves one nibble per cycle while m_tready is high; that port sets the sustained
// rate: a printed character costs two nibbles, four when it wraps to the next row.
// A stall on m_tready holds the output register; the queue fills behind it and then
// s_tready drops. The cfg port writes columns (index 0) and display_rows (index 1) and
// should be used only while no run is pending.
// Reset: columns 20, four rows, cursor at the top left, all display flags off, queue and
// output empty.
`default_nettype none

module character_lcd_4bit_command_sequencer_top
  import clcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // command[3:0]
  input  wire logic [CMD_W-1:0]      s_tuser,
  // byte_value[7:0], col[14:8], row[22:15], cgram_slot[25:23], flag_select[27:26],
  // flag_on[28], scroll_right[29], zero[31:30]
  input  wire logic [SDATA_W-1:0]    s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // nibble[3:0], zero[7:4]
  output logic [MDATA_W-1:0]         m_tdata,
  // register_select[0]
  output logic                       m_tuser,
  output logic                       m_tlast,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  logic push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  job_t push_job;
  job_t q_head;

  clcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  clcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  clcd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

>>> hdl/clcd_queue.sv
// Small job queue that decouples the command front end from the nibble back end.
`default_nettype none

module clcd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  clcd_pkg::job_t     push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output clcd_pkg::job_t     head
);
  import clcd_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/clcd_front.sv
// Front end: takes commands, tracks cursor and flags, and turns each command into a job.
`default_nettype none

module clcd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [clcd_pkg::CMD_W-1:0]    s_tuser,
  input  wire logic [clcd_pkg::SDATA_W-1:0]  s_tdata,
  input  wire logic                          cfg_wen,
  input  wire logic [clcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [clcd_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                          q_full,
  output logic                               push,
  output clcd_pkg::job_t                     job
);
  import clcd_pkg::*;

  // Configuration registers.
  logic [COLS_W-1:0] columns;
  logic [ROWS_W-1:0] display_rows;

  // Tracked display state.
  logic [7:0] cursor_col;
  logic [1:0] cursor_row;
  logic [2:0] display_flags;
  logic [7:0] cursor_col_next;
  logic [1:0] cursor_row_next;
  logic [2:0] display_flags_next;

  // Input fields.
  logic [7:0] byte_value;
  logic [6:0] col;
  logic [7:0] row;
  logic [2:0] cgram_slot;
  logic [1:0] flag_select;
  logic       flag_on;
  logic       scroll_right;
  logic       accept;
  logic       has_work;
  logic [ROWS_W-1:0] row_limit;

  assign byte_value   = s_tdata[7:0];
  assign col          = s_tdata[14:8];
  assign row          = s_tdata[22:15];
  assign cgram_slot   = s_tdata[25:23];
  assign flag_select  = s_tdata[27:26];
  assign flag_on      = s_tdata[28];
  assign scroll_right = s_tdata[29];

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign push      = accept && has_work;
  assign row_limit = (display_rows > ROW_LIMIT_MAX) ? ROW_LIMIT_MAX : display_rows;

  // A row at or beyond the row count goes back to the top row.
  function automatic logic [1:0] fold_row(input logic [7:0] r, input logic [ROWS_W-1:0] lim);
    return (r >= {5'b0, lim}) ? 2'd0 : r[1:0];
  endfunction

  // Set-address instruction for a column and row.
  function automatic logic [7:0] ddram_addr(input logic [7:0] c, input logic [1:0] r);
    return LCD_SET_DDRAM | {1'b0, c[6:0] + row_base(r)};
  endfunction

  // Command decode and cursor bookkeeping.
  always_comb begin
    logic       wrap;
    logic [7:0] c1;
    logic [1:0] r1;
    logic [1:0] r2;
    logic [7:0] addr_wrap;
    logic [7:0] second;
    logic       second_rs;
    logic [2:0] flag_bit;
    logic [2:0] new_flags;
    logic [1:0] tgt_row;

    cursor_col_next    = cursor_col;
    cursor_row_next    = cursor_row;
    display_flags_next = display_flags;
    has_work           = 1'b1;
    job                = '0;

    wrap      = (cursor_col >= {2'b0, columns});
    c1        = wrap ? 8'd0 : cursor_col;
    r1        = wrap ? fold_row({6'b0, cursor_row} + 8'd1, row_limit) : cursor_row;
    addr_wrap = ddram_addr(8'd0, r1);
    r2        = fold_row({6'b0, r1} + 8'd1, row_limit);
    flag_bit  = 3'b100 >> flag_select;
    new_flags = flag_on ? (display_flags | flag_bit) : (display_flags & ~flag_bit);
    tgt_row   = fold_row(row, row_limit);
    second    = byte_value;
    second_rs = 1'b1;

    unique case (s_tuser)
      CMD_INIT: begin
        job.init           = 1'b1;
        job.b0             = (display_rows > 3'd1) ? LCD_FUNC_2LINE : LCD_FUNC_1LINE;
        cursor_col_next    = 8'd0;
        cursor_row_next    = 2'd0;
        display_flags_next = FLAGS_INIT;
      end
      CMD_PUT_CHAR: begin
        // Character after any end-of-row wrap: newline, carriage return or data.
        if (byte_value == CHAR_LF) begin
          second          = ddram_addr(c1, r2);
          second_rs       = 1'b0;
          cursor_col_next = c1;
          cursor_row_next = r2;
        end else if (byte_value == CHAR_CR) begin
          second          = ddram_addr(8'd0, r1);
          second_rs       = 1'b0;
          cursor_col_next = 8'd0;
          cursor_row_next = r1;
        end else begin
          cursor_col_next = c1 + 8'd1;
          cursor_row_next = r1;
        end
        if (wrap) begin
          job.two = 1'b1;
          job.b0  = addr_wrap;
          job.rs0 = 1'b0;
          job.b1  = second;
          job.rs1 = second_rs;
        end else begin
          job.b0  = second;
          job.rs0 = second_rs;
        end
      end
      CMD_SET_CURSOR: begin
        job.b0          = ddram_addr({1'b0, col}, tgt_row);
        cursor_col_next = {1'b0, col};
        cursor_row_next = tgt_row;
      end
      CMD_PUT_CUSTOM: begin
        job.two         = 1'b1;
        job.b0          = ddram_addr({1'b0, col}, tgt_row);
        job.b1          = {5'b0, cgram_slot};
        job.rs1         = 1'b1;
        cursor_col_next = {1'b0, col};
        cursor_row_next = tgt_row;
      end
      CMD_CLEAR: begin
        job.b0 = LCD_CLEAR;
      end
      CMD_FLAG: begin
        // Only the three defined flags; the spare selector does nothing.
        if (flag_select == FLAG_DISPLAY || flag_select == FLAG_CURSOR ||
            flag_select == FLAG_BLINK) begin
          display_flags_next = new_flags;
          job.b0             = LCD_DISP_CTRL | {5'b0, new_flags};
        end else begin
          has_work = 1'b0;
        end
      end
      CMD_SCROLL: begin
        job.b0 = scroll_right ? LCD_SHIFT_RIGHT : LCD_SHIFT_LEFT;
      end
      CMD_CGRAM_SEL: begin
        job.b0 = LCD_SET_CGRAM | {2'b0, cgram_slot, 3'b0};
      end
      CMD_RAW_DATA: begin
        job.b0  = byte_value;
        job.rs0 = 1'b1;
      end
      default: begin
        has_work = 1'b0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns      <= COLS_RESET;
      display_rows <= ROWS_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_COLUMNS: columns      <= cfg_wdata[COLS_W-1:0];
        CFG_ROWS:    display_rows <= cfg_wdata[ROWS_W-1:0];
        default:     columns      <= columns;
      endcase
    end
  end

  // Cursor and flag state advance on every accepted command.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col    <= '0;
      cursor_row    <= '0;
      display_flags <= '0;
    end else if (accept) begin
      cursor_col    <= cursor_col_next;
      cursor_row    <= cursor_row_next;
      display_flags <= display_flags_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/clcd_back.sv
// Back end: splits each queued job into tagged nibbles and drives the output register.
`default_nettype none

module clcd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  clcd_pkg::job_t                     q_head,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [clcd_pkg::MDATA_W-1:0]       m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast
);
  import clcd_pkg::*;

  job_t                 job;
  logic                 busy;
  logic [NIB_IDX_W-1:0] idx;
  logic                 out_free;
  logic                 advance;
  logic [3:0]           nib;
  logic                 rs;
  logic                 last;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = busy && out_free;
  assign q_pop    = !q_empty && (!busy || (advance && last));

  // Nibble select for the current position in the job.
  always_comb begin
    if (job.init) begin
      nib  = init_nibble(idx, job.b0);
      rs   = 1'b0;
      last = (idx == INIT_NIBBLES - 1'b1);
    end else begin
      unique case (idx[1:0])
        2'd0: nib = job.b0[7:4];
        2'd1: nib = job.b0[3:0];
        2'd2: nib = job.b1[7:4];
        2'd3: nib = job.b1[3:0];
        default: nib = 4'h0;
      endcase
      rs   = idx[1] ? job.rs1 : job.rs0;
      last = job.two ? (idx == 4'd3) : (idx == 4'd1);
    end
  end

  // Job register and position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (advance) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0, nib};
      m_tuser <= rs;
      m_tlast <= last;
    end
  end

endmodule

`default_nettype wire

>>> hdl/clcd_checker.sv
// Port-level checks on the sequencer output and their binding to the top level.
`default_nettype none

module clcd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [clcd_pkg::MDATA_W-1:0]  m_tdata,
  input wire logic                          m_tuser,
  input wire logic                          m_tlast
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled nibble holds its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                 $stable(m_tlast)))
    else $error("stalled output changed");

  // Within a run the next nibble follows without a gap.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("gap inside a nibble run");

  // A data nibble inside a run is followed by another data nibble with bits 7:4 zero.
  a_data_pairs: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast && m_tuser) |=> (m_tuser && m_tdata[7:4] == 4'h0))
    else $error("data byte split across register select");

endmodule

bind character_lcd_4bit_command_sequencer_top clcd_checker u_clcd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
